>>> rtl/scrs_pkg.sv
// Package for the sprite corner block: payload types, CORDIC angle table
// and the saturating Q16 product helper. No dependencies.
`default_nettype none
package scrs_pkg;

  typedef struct packed {
    logic signed [31:0] sprite_width;
    logic signed [31:0] sprite_height;
    logic signed [31:0] dest_x;
    logic signed [31:0] dest_y;
    logic signed [31:0] pivot_x;
    logic signed [31:0] pivot_y;
    logic        [23:0] turn_angle;
    logic signed [31:0] scale_horiz;
    logic signed [31:0] scale_vert;
    logic               flip_horiz;
    logic               flip_vert;
  } scrs_in_t;

  typedef struct packed {
    logic signed [31:0] corner0_x;
    logic signed [31:0] corner0_y;
    logic signed [31:0] corner1_x;
    logic signed [31:0] corner1_y;
    logic signed [31:0] corner2_x;
    logic signed [31:0] corner2_y;
    logic signed [31:0] corner3_x;
    logic signed [31:0] corner3_y;
  } scrs_out_t;

  localparam int AtanEntries = 30;
  localparam logic signed [33:0] CordicX0 = 34'sd652032875;
  localparam logic signed [17:0] Q16One = 18'sd65536;

  function automatic logic signed [33:0] atan_turn(input logic [4:0] k);
    logic signed [33:0] r;
    case (k)
      5'd0: r = 34'sd536870912;  5'd1: r = 34'sd316933406;
      5'd2: r = 34'sd167458907;  5'd3: r = 34'sd85004756;
      5'd4: r = 34'sd42667331;   5'd5: r = 34'sd21354465;
      5'd6: r = 34'sd10679838;   5'd7: r = 34'sd5340245;
      5'd8: r = 34'sd2670163;    5'd9: r = 34'sd1335087;
      5'd10: r = 34'sd667544;    5'd11: r = 34'sd333772;
      5'd12: r = 34'sd166886;    5'd13: r = 34'sd83443;
      5'd14: r = 34'sd41722;     5'd15: r = 34'sd20861;
      5'd16: r = 34'sd10430;     5'd17: r = 34'sd5215;
      5'd18: r = 34'sd2608;      5'd19: r = 34'sd1304;
      5'd20: r = 34'sd652;       5'd21: r = 34'sd326;
      5'd22: r = 34'sd163;       5'd23: r = 34'sd81;
      5'd24: r = 34'sd41;        5'd25: r = 34'sd20;
      5'd26: r = 34'sd10;        5'd27: r = 34'sd5;
      5'd28: r = 34'sd3;         5'd29: r = 34'sd1;
      default: r = 34'sd0;
    endcase
    return r;
  endfunction

  // Shift a 64-bit product right by 16 and saturate it to 32 bits.
  function automatic logic signed [31:0] sat_q16(input logic signed [63:0] p);
    logic signed [47:0] s;
    s = p[63:16];
    if (s > 48'sd2147483647) return 32'sh7fffffff;
    if (s < -48'sd2147483648) return 32'sh80000000;
    return s[31:0];
  endfunction

endpackage
`default_nettype wire

>>> rtl/scrs_if.sv
// Valid/ready channel carrying one payload of a given type.
// Depends on nothing; payload types come from scrs_pkg.
`default_nettype none
interface scrs_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/sprite_corner_rotate_scale.sv
// Top level of the sprite corner block: CORDIC sine/cosine pipeline,
// scale and rotate multiplies and corner assembly. Uses scrs_pkg, scrs_if.
//
//   channel   dir  payload     meaning
//   in_req    in   scrs_in_t   one sprite placement
//   out_req   out  scrs_out_t  four corners in slot order
//
// A request passes stage 0, the CORDIC stages (one rotation each), stages A
// to D and the output register; one enters every cycle while not stalled.
// Reset clears only the valid bits. The whole pipeline advances when the
// output register is empty or being taken, so a stall holds every stage.
`default_nettype none
module sprite_corner_rotate_scale #(
  parameter int CORDIC_STAGES = 24
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  scrs_if.sink      in_req,
  scrs_if.source    out_req
);
  import scrs_pkg::*;

  localparam int NSt = CORDIC_STAGES;
  localparam int NPipe = NSt + 6;

  logic adv;
  logic [NPipe-1:0] vld_q;
  assign adv = !vld_q[NPipe-1] || out_req.ready;
  assign in_req.ready = adv;
  assign out_req.valid = vld_q[NPipe-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NPipe-2:0], in_req.valid};
    end
  end

  // Stage 0: angle reduction and the four scale multiplies.
  logic signed [33:0] z0_d;
  logic neg0_d;
  always_comb begin
    logic signed [24:0] a;
    a = $signed({in_req.data.turn_angle[23], in_req.data.turn_angle});
    neg0_d = 1'b0;
    if (a > 25'sd4194304) begin
      a = a - 25'sd8388608; neg0_d = 1'b1;
    end else if (a < -25'sd4194304) begin
      a = a + 25'sd8388608; neg0_d = 1'b1;
    end
    z0_d = {{1{a[24]}}, a, 8'd0};
  end

  logic signed [33:0] x_q [NSt+1];
  logic signed [33:0] y_q [NSt+1];
  logic signed [33:0] z_q [NSt+1];
  logic neg_q [NSt+1];
  scrs_in_t dat_q [NSt+1];
  logic signed [31:0] w_q [NSt+1], h_q [NSt+1], cx_q [NSt+1], cy_q [NSt+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x_q[0] <= CordicX0;
      y_q[0] <= '0;
      z_q[0] <= z0_d;
      neg_q[0] <= neg0_d;
      dat_q[0] <= in_req.data;
      w_q[0] <= sat_q16(64'(in_req.data.sprite_width) * 64'(in_req.data.scale_horiz));
      h_q[0] <= sat_q16(64'(in_req.data.sprite_height) * 64'(in_req.data.scale_vert));
      cx_q[0] <= sat_q16(64'(in_req.data.pivot_x) * 64'(in_req.data.scale_horiz));
      cy_q[0] <= sat_q16(64'(in_req.data.pivot_y) * 64'(in_req.data.scale_vert));
    end
  end

  // CORDIC rotation stages, one per register.
  for (genvar i = 0; i < NSt; i++) begin : g_cordic
    localparam logic [4:0] K = 5'(i % AtanEntries);
    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (!z_q[i][33]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> K);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> K);
          z_q[i+1] <= z_q[i] - atan_turn(K);
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> K);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> K);
          z_q[i+1] <= z_q[i] + atan_turn(K);
        end
        neg_q[i+1] <= neg_q[i];
        dat_q[i+1] <= dat_q[i];
        w_q[i+1] <= w_q[i];
        h_q[i+1] <= h_q[i];
        cx_q[i+1] <= cx_q[i];
        cy_q[i+1] <= cy_q[i];
      end
    end
  end

  function automatic logic signed [17:0] to_q16(input logic signed [33:0] v,
                                               input logic neg);
    logic signed [33:0] m;
    logic signed [33:0] r;
    m = v[33] ? -v : v;
    r = (m + 34'sd8192) >>> 14;
    if (r > 34'(Q16One)) r = 34'(Q16One);
    if (v[33]) r = -r;
    if (neg) r = -r;
    return r[17:0];
  endfunction

  // Stage A: Q16 sine and cosine.
  logic signed [17:0] s_q, c_q;
  scrs_in_t da_q;
  logic signed [31:0] wa_q, ha_q, cxa_q, cya_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_q <= to_q16(x_q[NSt], neg_q[NSt]);
      s_q <= to_q16(y_q[NSt], neg_q[NSt]);
      da_q <= dat_q[NSt];
      wa_q <= w_q[NSt]; ha_q <= h_q[NSt]; cxa_q <= cx_q[NSt]; cya_q <= cy_q[NSt];
    end
  end

  // Stage B: the eight rotation multiplies.
  logic signed [31:0] cxc_q, cys_q, cxs_q, cyc_q, wc_q, ws_q, hs_q, hc_q;
  scrs_in_t db_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      cxc_q <= sat_q16(64'(cxa_q) * 64'(c_q));
      cys_q <= sat_q16(64'(cya_q) * 64'(s_q));
      cxs_q <= sat_q16(64'(cxa_q) * 64'(s_q));
      cyc_q <= sat_q16(64'(cya_q) * 64'(c_q));
      wc_q <= sat_q16(64'(wa_q) * 64'(c_q));
      ws_q <= sat_q16(64'(wa_q) * 64'(s_q));
      hs_q <= sat_q16(64'(ha_q) * 64'(s_q));
      hc_q <= sat_q16(64'(ha_q) * 64'(c_q));
      db_q <= da_q;
    end
  end

  // Stage C: origin offset.
  logic [31:0] xo_q, yo_q;
  logic [31:0] wc2_q, ws2_q, hs2_q, hc2_q;
  logic fh_q, fv_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      xo_q <= db_q.dest_x - cxc_q + cys_q;
      yo_q <= db_q.dest_y - cxs_q - cyc_q;
      wc2_q <= wc_q; ws2_q <= ws_q; hs2_q <= hs_q; hc2_q <= hc_q;
      fh_q <= db_q.flip_horiz; fv_q <= db_q.flip_vert;
    end
  end

  // Stage D: corners, then slot permutation into the output register.
  logic [31:0] tlx_q, tly_q, trx_q, try_q, blx_q, bly_q, brx_q, bry_q;
  logic fh2_q, fv2_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      tlx_q <= xo_q; tly_q <= yo_q;
      trx_q <= xo_q + wc2_q; try_q <= yo_q + ws2_q;
      blx_q <= xo_q - hs2_q; bly_q <= yo_q + hc2_q;
      brx_q <= xo_q + wc2_q - hs2_q; bry_q <= yo_q + ws2_q + hc2_q;
      fh2_q <= fh_q; fv2_q <= fv_q;
    end
  end

  logic [31:0] t0x, t0y, t1x, t1y, b0x, b0y, b1x, b1y;
  scrs_out_t o_d, o_q;
  always_comb begin
    // Left/right pair on each row after the horizontal flip.
    t0x = fh2_q ? trx_q : tlx_q; t0y = fh2_q ? try_q : tly_q;
    t1x = fh2_q ? tlx_q : trx_q; t1y = fh2_q ? tly_q : try_q;
    b0x = fh2_q ? brx_q : blx_q; b0y = fh2_q ? bry_q : bly_q;
    b1x = fh2_q ? blx_q : brx_q; b1y = fh2_q ? bly_q : bry_q;
    if (fv2_q) begin
      o_d.corner0_x = b0x; o_d.corner0_y = b0y;
      o_d.corner1_x = b1x; o_d.corner1_y = b1y;
      o_d.corner2_x = t1x; o_d.corner2_y = t1y;
      o_d.corner3_x = t0x; o_d.corner3_y = t0y;
    end else begin
      o_d.corner0_x = t0x; o_d.corner0_y = t0y;
      o_d.corner1_x = t1x; o_d.corner1_y = t1y;
      o_d.corner2_x = b1x; o_d.corner2_y = b1y;
      o_d.corner3_x = b0x; o_d.corner3_y = b0y;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) o_q <= o_d;
  end
  assign out_req.data = o_q;

endmodule
`default_nettype wire
